[src/md5bc_pkg.sv]
// Shared types, constants and microcode for the MD5 block compression engine.
`default_nettype none

package md5bc_pkg;

   // Block geometry.
   localparam int WORDS_PER_BLOCK = 16;
   localparam int WORD_IDX_W      = $clog2(WORDS_PER_BLOCK);
   localparam int STEP_COUNT      = 64;
   localparam int STEP_W          = $clog2(STEP_COUNT);
   localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(STEP_COUNT - 1);
   localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(WORDS_PER_BLOCK - 1);

   // Payload of one input transfer.
   typedef struct packed {
      logic [31:0] message_word;
      logic        restart;
   } req_payload_type;

   // Payload of one result transfer.
   typedef struct packed {
      logic [31:0] chain_a;
      logic [31:0] chain_b;
      logic [31:0] chain_c;
      logic [31:0] chain_d;
   } rsp_payload_type;

   // Standard initial chaining value.
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // Additive constants, one per step.
   localparam logic [31:0] MD5_SINE [STEP_COUNT] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts, indexed by {round, step within group of four}.
   localparam logic [4:0] MD5_ROT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   // Rounds of sixteen steps each.
   typedef enum logic [1:0] {
      ROUND_F = 2'd0,
      ROUND_G = 2'd1,
      ROUND_H = 2'd2,
      ROUND_I = 2'd3
   } round_type;

   // Message word used by a step, from its round and low four step bits.
   function automatic logic [WORD_IDX_W-1:0] msg_index(input round_type rnd,
                                                       input logic [WORD_IDX_W-1:0] idx);
      logic [WORD_IDX_W-1:0] res;
      begin
         case (rnd)
            ROUND_F: res = idx;
            ROUND_G: res = WORD_IDX_W'(4'd1 + (idx << 2) + idx);
            ROUND_H: res = WORD_IDX_W'(4'd5 + (idx << 1) + idx);
            ROUND_I: res = WORD_IDX_W'((idx << 3) - idx);
            default: res = idx;
         endcase
         return res;
      end
   endfunction

   // Rotate a word left by a non-zero amount.
   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] dbl;
      begin
         dbl = {x, x} << s;
         return dbl[63:32];
      end
   endfunction

   // Microcode sequencing.
   localparam int PC_W        = 2;
   localparam int UCODE_DEPTH = 2 ** PC_W;

   localparam logic [PC_W-1:0] PC_COLLECT = 2'd0;
   localparam logic [PC_W-1:0] PC_LOAD    = 2'd1;
   localparam logic [PC_W-1:0] PC_ROUND   = 2'd2;
   localparam logic [PC_W-1:0] PC_FINAL   = 2'd3;

   // Jump conditions: when the condition holds the sequencer goes to the
   // target, otherwise it falls through to the next control word.
   typedef enum logic [1:0] {
      COND_NEVER      = 2'd0,
      COND_WAIT_BLOCK = 2'd1,
      COND_ROUND_LOOP = 2'd2,
      COND_WAIT_OUT   = 2'd3
   } cond_type;

   typedef struct packed {
      logic            accept_en;
      logic            load_work;
      logic            do_round;
      logic            finalize;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   // The control program.
   localparam ctrl_word_type MD5BC_UCODE [UCODE_DEPTH] = '{
      '{accept_en: 1'b1, load_work: 1'b0, do_round: 1'b0, finalize: 1'b0,
        cond: COND_WAIT_BLOCK, target: PC_COLLECT},
      '{accept_en: 1'b0, load_work: 1'b1, do_round: 1'b0, finalize: 1'b0,
        cond: COND_NEVER, target: PC_COLLECT},
      '{accept_en: 1'b0, load_work: 1'b0, do_round: 1'b1, finalize: 1'b0,
        cond: COND_ROUND_LOOP, target: PC_ROUND},
      '{accept_en: 1'b0, load_work: 1'b0, do_round: 1'b0, finalize: 1'b1,
        cond: COND_WAIT_OUT, target: PC_FINAL}
   };

endpackage

`default_nettype wire

[src/md5_block_compress_top.sv]
// MD5 block compression engine: microcoded sequencer over a one-step-per-cycle datapath.
// Words of a block are taken one per cycle while the sequencer collects; the compression
// starts on the sixteenth. After a block's last word is taken, one load step, 64 round
// steps sharing one adder chain and one final add (held while a result waits) follow.
// The next block's words are not taken until the result of this block is registered.
// Synchronous reset loads the standard initial value and empties the result register.
`default_nettype none

module md5_block_compress_top import md5bc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   // Sequencer state.
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [STEP_W-1:0]     step_ff;
   logic [WORD_IDX_W-1:0] count_ff;

   // Chaining value, working variables and block buffer.
   logic [31:0] chain_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] buf_ff [WORDS_PER_BLOCK];

   // Result register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   ctrl_word_type         cw;
   logic                  req_xfer;
   logic                  last_word;
   logic [WORD_IDX_W-1:0] wr_idx;
   logic                  out_busy;
   logic                  taken;
   logic                  final_fire;

   round_type             rnd;
   logic [WORD_IDX_W-1:0] m_idx;
   logic [31:0]           f_val;
   logic [31:0]           t_val;
   logic [31:0]           b_new;
   logic [31:0]           sum_a, sum_b, sum_c, sum_d;

   // Current control word.
   assign cw = MD5BC_UCODE[pc_ff];

   // Input side: words are taken only in the collecting step.
   assign req_stall = !cw.accept_en;
   assign req_xfer  = req_valid && !req_stall;
   assign wr_idx    = req_payload.restart ? '0 : count_ff;
   assign last_word = req_xfer && (wr_idx == WORD_LAST);

   // The result register is occupied while a result waits to be taken.
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign final_fire = cw.finalize && !out_busy;

   // Jump condition evaluation and next step.
   always_comb begin
      case (cw.cond)
         COND_NEVER:      taken = 1'b0;
         COND_WAIT_BLOCK: taken = !last_word;
         COND_ROUND_LOOP: taken = (step_ff != STEP_LAST);
         COND_WAIT_OUT:   taken = out_busy;
         default:         taken = 1'b0;
      endcase
      pc_in = taken ? cw.target : pc_ff + PC_W'(1);
   end

   // One MD5 step.
   always_comb begin
      rnd   = round_type'(step_ff[STEP_W-1:STEP_W-2]);
      m_idx = msg_index(rnd, step_ff[WORD_IDX_W-1:0]);
      case (rnd)
         ROUND_F: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         ROUND_G: f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         ROUND_H: f_val = b_ff ^ c_ff ^ d_ff;
         ROUND_I: f_val = c_ff ^ (b_ff | ~d_ff);
         default: f_val = b_ff ^ c_ff ^ d_ff;
      endcase
      t_val = a_ff + f_val + buf_ff[m_idx] + MD5_SINE[step_ff];
      b_new = b_ff + rotl32(t_val, MD5_ROT[{rnd, step_ff[1:0]}]);
   end

   // Final feed-forward into the chaining value.
   assign sum_a = chain_ff[0] + a_ff;
   assign sum_b = chain_ff[1] + b_ff;
   assign sum_c = chain_ff[2] + c_ff;
   assign sum_d = chain_ff[3] + d_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_COLLECT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff[0]  <= IV_A;
         chain_ff[1]  <= IV_B;
         chain_ff[2]  <= IV_C;
         chain_ff[3]  <= IV_D;
      end else begin
         pc_ff <= pc_in;
         if (req_xfer) begin
            count_ff <= wr_idx + WORD_IDX_W'(1);
            if (req_payload.restart) begin
               chain_ff[0] <= IV_A;
               chain_ff[1] <= IV_B;
               chain_ff[2] <= IV_C;
               chain_ff[3] <= IV_D;
            end
         end
         if (final_fire) begin
            chain_ff[0]  <= sum_a;
            chain_ff[1]  <= sum_b;
            chain_ff[2]  <= sum_c;
            chain_ff[3]  <= sum_d;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         buf_ff[wr_idx] <= req_payload.message_word;
      end
      if (cw.load_work) begin
         a_ff    <= chain_ff[0];
         b_ff    <= chain_ff[1];
         c_ff    <= chain_ff[2];
         d_ff    <= chain_ff[3];
         step_ff <= '0;
      end
      if (cw.do_round) begin
         a_ff    <= d_ff;
         d_ff    <= c_ff;
         c_ff    <= b_ff;
         b_ff    <= b_new;
         step_ff <= step_ff + STEP_W'(1);
      end
      if (final_fire) begin
         rsp_payload_ff.chain_a <= sum_a;
         rsp_payload_ff.chain_b <= sum_b;
         rsp_payload_ff.chain_c <= sum_c;
         rsp_payload_ff.chain_d <= sum_d;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire
